// ----- rtl/core/perceptron_online_trainer_unit_macros.svh -----
// Assertion macros for the perceptron trainer checker.
// Uses the clk and arst_n names of the module that includes it.
`ifndef PERCEPTRON_ONLINE_TRAINER_UNIT_MACROS_SVH
`define PERCEPTRON_ONLINE_TRAINER_UNIT_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define POT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, gated off during reset.
`define POT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/pot_pkg.sv -----
// Shared types, codes and saturating add for the perceptron trainer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package pot_pkg;

	localparam int FEATURE_COUNT_DEF = 2;
	localparam int FEAT_W            = 16;
	localparam int WEIGHT_W          = 32;
	localparam int RATE_W            = 16;
	localparam int PROD_W            = WEIGHT_W + FEAT_W;
	localparam int DELTA_W           = WEIGHT_W + 2;
	localparam int CFG_IDX_W         = 8;
	localparam int CFG_DATA_W        = 32;
	localparam int OUTQ_DEPTH        = 2;
	localparam int RATE_RESET        = 6554;

	typedef enum logic [1:0] {
		MODE_PREDICT = 2'd0,
		MODE_TRAIN   = 2'd1,
		MODE_LOAD    = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RATE = 8'd0,
		REG_IW0  = 8'd1,
		REG_IW1  = 8'd2,
		REG_BIAS = 8'd3
	} reg_idx_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] value;
		logic                clip;
	} sat_t;

	typedef struct packed {
		logic prediction;
		logic updated;
		logic saturated;
	} res_t;

	// Q15.16 add with clipping to the 32-bit range.
	function automatic sat_t sat_add(input logic signed [WEIGHT_W-1:0] cur,
	                                 input logic signed [DELTA_W-1:0] delta);
		logic signed [DELTA_W-1:0] s;
		sat_t r;
		s = DELTA_W'(cur) + delta;
		r.clip = 1'b0;
		r.value = s[WEIGHT_W-1:0];
		if (!s[DELTA_W-1] && (s[DELTA_W-2:WEIGHT_W-1] != '0)) begin
			r.value = {1'b0, {(WEIGHT_W-1){1'b1}}};
			r.clip = 1'b1;
		end else if (s[DELTA_W-1] && (s[DELTA_W-2:WEIGHT_W-1] != '1)) begin
			r.value = {1'b1, {(WEIGHT_W-1){1'b0}}};
			r.clip = 1'b1;
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/perceptron_online_trainer_unit.sv -----
// Results are registered into the output queue as their items are accepted.
// Throughput: one item per cycle while the output queue has room; the weight
// loop (multiply, sum, compare, saturating update) is combinational and sets that figure.
// A two-entry output queue keeps input open while one result waits.
// Reset clears weights, bias and queue, and returns registers to reset values.
`timescale 1ns / 1ps

module perceptron_online_trainer_unit #(
	parameter int FEATURE_COUNT = pot_pkg::FEATURE_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// item input
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         mode,
	input  logic signed [pot_pkg::FEAT_W-1:0]  feature_0,
	input  logic signed [pot_pkg::FEAT_W-1:0]  feature_1,
	input  logic                               target,
	// result output
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               prediction,
	output logic                               updated,
	output logic                               saturated,
	// register writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pot_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pot_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int QPTR_W = $clog2(pot_pkg::OUTQ_DEPTH);
	localparam int QCNT_W = $clog2(pot_pkg::OUTQ_DEPTH + 1);

	// configuration registers
	logic [pot_pkg::RATE_W-1:0]          rate_q;
	logic signed [pot_pkg::WEIGHT_W-1:0] iw0_q;
	logic signed [pot_pkg::WEIGHT_W-1:0] iw1_q;
	logic signed [pot_pkg::WEIGHT_W-1:0] ibias_q;

	// learned state
	logic signed [pot_pkg::WEIGHT_W-1:0] weight_q [FEATURE_COUNT];
	logic signed [pot_pkg::WEIGHT_W-1:0] bias_q;

	logic [FEATURE_COUNT-1:0][pot_pkg::PROD_W-1:0] products;
	pot_pkg::sat_t                        lane_next [FEATURE_COUNT];
	logic [FEATURE_COUNT-1:0]             lane_clip;
	pot_pkg::sat_t                        bias_next;
	logic                                 pred;
	logic                                 accept;
	logic                                 train_fire;
	logic                                 load_fire;
	pot_pkg::res_t                        res;

	// output queue
	pot_pkg::res_t     slot_q [pot_pkg::OUTQ_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;

	// The user must make writes arrive only while idle; the block does not enforce this. The port is always open.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q  <= pot_pkg::RATE_W'(pot_pkg::RATE_RESET);
			iw0_q   <= '0;
			iw1_q   <= '0;
			ibias_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pot_pkg::REG_RATE: rate_q  <= cfg_data[pot_pkg::RATE_W-1:0];
				pot_pkg::REG_IW0:  iw0_q   <= cfg_data;
				pot_pkg::REG_IW1:  iw1_q   <= cfg_data;
				pot_pkg::REG_BIAS: ibias_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = (count_q != QCNT_W'(pot_pkg::OUTQ_DEPTH));
	assign accept   = in_valid && in_ready;

	// Lanes: one multiply and one weight candidate per feature.
	for (genvar i = 0; i < FEATURE_COUNT; i++) begin : g_lane
		logic signed [pot_pkg::FEAT_W-1:0]   x;
		logic signed [pot_pkg::WEIGHT_W-1:0] init_w;
		logic signed [pot_pkg::PROD_W-1:0]   prod;

		if (i == 0) begin : g_f0
			assign x      = feature_0;
			assign init_w = iw0_q;
		end else if (i == 1) begin : g_f1
			assign x      = feature_1;
			assign init_w = iw1_q;
		end else begin : g_fz
			// features past the second are zero, loaded weights too
			assign x      = '0;
			assign init_w = '0;
		end

		pot_lane u_lane (
			.weight      (weight_q[i]),
			.feature     (x),
			.step_size   (rate_q),
			.target      (target),
			.product     (prod),
			.next_weight (lane_next[i])
		);

		assign products[i]  = prod;
		assign lane_clip[i] = lane_next[i].clip;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				weight_q[i] <= '0;
			end else if (train_fire) begin
				weight_q[i] <= lane_next[i].value;
			end else if (load_fire) begin
				weight_q[i] <= init_w;
			end
		end
	end

	pot_merge #(
		.FEATURE_COUNT (FEATURE_COUNT)
	) u_merge (
		.products   (products),
		.bias       (bias_q),
		.step_size  (rate_q),
		.target     (target),
		.prediction (pred),
		.next_bias  (bias_next)
	);

	// Train only fires on a wrong prediction; mode 3 acts as predict.
	assign train_fire = accept && (mode == pot_pkg::MODE_TRAIN) && (target != pred);
	assign load_fire  = accept && (mode == pot_pkg::MODE_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
		end else if (train_fire) begin
			bias_q <= bias_next.value;
		end else if (load_fire) begin
			bias_q <= ibias_q;
		end
	end

	assign res.prediction = pred;
	assign res.updated    = train_fire;
	assign res.saturated  = train_fire && ((|lane_clip) || bias_next.clip);

	// Output queue: results wait here until taken.
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (accept && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !accept) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q[wr_ptr_q] <= res;
		end
	end

	assign out_valid  = (count_q != '0);
	assign prediction = slot_q[rd_ptr_q].prediction;
	assign updated    = slot_q[rd_ptr_q].updated;
	assign saturated  = slot_q[rd_ptr_q].saturated;

endmodule

// ----- rtl/core/pot_lane.sv -----
// One feature lane: weight*feature product and the trained weight candidate.
// Depends on pot_pkg.
`timescale 1ns / 1ps

module pot_lane (
	input  logic signed [pot_pkg::WEIGHT_W-1:0] weight,
	input  logic signed [pot_pkg::FEAT_W-1:0]   feature,
	input  logic [pot_pkg::RATE_W-1:0]          step_size,
	input  logic                                target,
	output logic signed [pot_pkg::PROD_W-1:0]   product,
	output pot_pkg::sat_t                       next_weight
);

	logic [pot_pkg::FEAT_W-1:0]                mag;
	logic [pot_pkg::RATE_W+pot_pkg::FEAT_W-1:0] scaled;
	logic [pot_pkg::RATE_W+pot_pkg::FEAT_W:0]   rounded;
	logic [pot_pkg::RATE_W+pot_pkg::FEAT_W-13:0] step;
	logic                                      neg;
	logic signed [pot_pkg::DELTA_W-1:0]        step_ext;
	logic signed [pot_pkg::DELTA_W-1:0]        delta;

	assign product = weight * feature;

	// |x| fits 16 bits unsigned, most negative value included
	assign mag      = feature[pot_pkg::FEAT_W-1] ? pot_pkg::FEAT_W'(-feature) : feature;
	assign scaled   = step_size * mag;
	// Q.28 -> Q.16, ties away from zero; the sum never reaches bit 32
	assign rounded  = (pot_pkg::RATE_W+pot_pkg::FEAT_W+1)'(scaled) + 'd2048;
	assign step     = rounded[pot_pkg::RATE_W+pot_pkg::FEAT_W-1:12];
	// target high means the error is +1
	assign neg      = feature[pot_pkg::FEAT_W-1] ^ ~target;
	assign step_ext = $signed(pot_pkg::DELTA_W'(step));
	assign delta    = neg ? -step_ext : step_ext;

	assign next_weight = pot_pkg::sat_add(weight, delta);

endmodule

// ----- rtl/core/pot_merge.sv -----
// Merge stage: sums lane products with the bias, step activation, bias update.
// Depends on pot_pkg.
`timescale 1ns / 1ps

module pot_merge #(
	parameter int FEATURE_COUNT = pot_pkg::FEATURE_COUNT_DEF
) (
	input  logic [FEATURE_COUNT-1:0][pot_pkg::PROD_W-1:0] products,
	input  logic signed [pot_pkg::WEIGHT_W-1:0]           bias,
	input  logic [pot_pkg::RATE_W-1:0]                    step_size,
	input  logic                                          target,
	output logic                                          prediction,
	output pot_pkg::sat_t                                 next_bias
);

	localparam int NET_W = pot_pkg::PROD_W + $clog2(FEATURE_COUNT + 1);

	logic signed [NET_W-1:0]            net;
	logic signed [pot_pkg::DELTA_W-1:0] rate_ext;

	always_comb begin
		// bias is Q.16, products are Q.28
		net = NET_W'(bias) <<< 12;
		for (int i = 0; i < FEATURE_COUNT; i++) begin
			net = net + NET_W'($signed(products[i]));
		end
	end

	assign prediction = ~net[NET_W-1];
	assign rate_ext   = $signed(pot_pkg::DELTA_W'(step_size));
	assign next_bias  = pot_pkg::sat_add(bias, target ? rate_ext : -rate_ext);

endmodule

// ----- rtl/core/pot_checker.sv -----
// Port-level checks for the perceptron trainer, bound to the top level.
// Depends on pot_pkg and perceptron_online_trainer_unit_macros.svh.
`timescale 1ns / 1ps
`include "perceptron_online_trainer_unit_macros.svh"

module pot_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic                           prediction,
	input logic                           updated,
	input logic                           saturated,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [pot_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [pot_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [2:0] res_bits;

	assign res_bits = {prediction, updated, saturated};

	// clipping can only come from an actual update
	`POT_ASSERT_NOW(a_sat_needs_upd, out_valid && saturated, updated, "saturated without update")
	// input only closes while results are backed up
	`POT_ASSERT_NOW(a_stall_cause, !in_ready, out_valid, "input stalled with empty queue")
	// every accepted item shows a result the next cycle
	`POT_ASSERT_NEXT(a_result_next, in_valid && in_ready, out_valid, "no result after item")
	// a waiting result holds
	`POT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(res_bits),
		"result changed while stalled")
	// register writes are never refused
	`POT_ASSERT_NOW(a_cfg_open, cfg_valid, cfg_ready && (cfg_index == cfg_index)
		&& (cfg_data == cfg_data), "config write refused")

endmodule

bind perceptron_online_trainer_unit pot_checker u_pot_checker (.*);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for perceptron_online_trainer_unit: a directed script, then
// random training phases; results are checked against typed or predicted values.
// Depends on pot_pkg and the unit's RTL only.

module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 150;
	localparam logic [1:0] MODE_SPARE = 2'd3;       // unused code, acts as predict
	localparam logic [pot_pkg::CFG_IDX_W-1:0] REG_UNUSED_LOW = 8'd4;
	localparam logic [pot_pkg::CFG_IDX_W-1:0] REG_UNUSED_TOP = 8'hFF;
	localparam logic signed [pot_pkg::WEIGHT_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [pot_pkg::WEIGHT_W-1:0] Q_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [1:0]                        op;
		logic signed [pot_pkg::FEAT_W-1:0] x0;
		logic signed [pot_pkg::FEAT_W-1:0] x1;
		logic                              tgt;
	} stim_t;

	typedef enum logic { ROW_ITEM, ROW_WRITE } row_kind_t;

	typedef struct {
		row_kind_t                      kind;
		stim_t                          s;
		logic [pot_pkg::CFG_IDX_W-1:0]  idx;
		logic [pot_pkg::CFG_DATA_W-1:0] data;
		bit                             typed;
		pot_pkg::res_t                  want;
	} script_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] mode;
	logic signed [pot_pkg::FEAT_W-1:0] feature_0;
	logic signed [pot_pkg::FEAT_W-1:0] feature_1;
	logic target;
	logic out_valid;
	logic out_ready;
	logic prediction;
	logic updated;
	logic saturated;
	logic cfg_valid;
	logic cfg_ready;
	logic [pot_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [pot_pkg::CFG_DATA_W-1:0] cfg_data;

	// typed-in expectation travels with the item it belongs to
	bit            typed_valid;
	pot_pkg::res_t typed_res;

	bit quiet_tail;
	bit gaps_on;
	int mismatch_count;
	int cycle_count;
	pot_pkg::res_t pending_results[$];

	// mirror of the unit's registers and learned state
	logic [pot_pkg::RATE_W-1:0]          rate_q      = pot_pkg::RATE_W'(pot_pkg::RATE_RESET);
	logic signed [pot_pkg::WEIGHT_W-1:0] init_w_q[2] = '{default: '0};
	logic signed [pot_pkg::WEIGHT_W-1:0] init_bias_q = '0;
	logic signed [pot_pkg::WEIGHT_W-1:0] w_q[2]      = '{default: '0};
	logic signed [pot_pkg::WEIGHT_W-1:0] bias_q      = '0;

	perceptron_online_trainer_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.feature_0 (feature_0),
		.feature_1 (feature_1),
		.target    (target),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.prediction(prediction),
		.updated   (updated),
		.saturated (saturated),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Q15.16 add, clipped to the 32-bit range
	function automatic logic signed [pot_pkg::WEIGHT_W-1:0] clip_add(
		input logic signed [pot_pkg::WEIGHT_W-1:0] cur, input longint delta,
		inout logic clip);
		longint s;
		s = longint'(cur) + delta;
		if (s > longint'(Q_MAX)) begin
			s = longint'(Q_MAX);
			clip = 1'b1;
		end else if (s < longint'(Q_MIN)) begin
			s = longint'(Q_MIN);
			clip = 1'b1;
		end
		return s[pot_pkg::WEIGHT_W-1:0];
	endfunction

	// Step activation on the old weights, then the learning rule or a load.
	function automatic pot_pkg::res_t classify_and_train(input logic [1:0] op,
		input logic signed [pot_pkg::FEAT_W-1:0] x0,
		input logic signed [pot_pkg::FEAT_W-1:0] x1, input logic tgt);
		longint xv[2];
		longint net_in;
		longint mag;
		longint stp;
		logic clip;
		pot_pkg::res_t r;
		xv[0] = x0;
		xv[1] = x1;
		net_in = longint'(bias_q) * 4096;
		for (int i = 0; i < 2; i++)
			net_in += longint'(w_q[i]) * xv[i];
		r.prediction = (net_in >= 0);
		r.updated = 1'b0;
		clip = 1'b0;
		if (op == pot_pkg::MODE_TRAIN && tgt != r.prediction) begin
			r.updated = 1'b1;
			for (int i = 0; i < 2; i++) begin
				mag = (xv[i] < 0) ? -xv[i] : xv[i];
				// magnitude rounded half away from zero, sign applied after
				stp = (longint'(rate_q) * mag + 2048) >>> 12;
				if ((xv[i] < 0) != (tgt == 1'b0))
					stp = -stp;
				w_q[i] = clip_add(w_q[i], stp, clip);
			end
			bias_q = clip_add(bias_q, tgt ? longint'(rate_q) : -longint'(rate_q), clip);
		end else if (op == pot_pkg::MODE_LOAD) begin
			w_q[0] = init_w_q[0];
			w_q[1] = init_w_q[1];
			bias_q = init_bias_q;
		end
		r.saturated = clip;
		return r;
	endfunction

	task automatic check_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0b, actual %0b", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Monitor: register writes, accepted items and results, all on the edge.
	always @(posedge clk) begin
		pot_pkg::res_t r;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pot_pkg::REG_RATE: rate_q = cfg_data[pot_pkg::RATE_W-1:0];
					pot_pkg::REG_IW0:  init_w_q[0] = cfg_data;
					pot_pkg::REG_IW1:  init_w_q[1] = cfg_data;
					pot_pkg::REG_BIAS: init_bias_q = cfg_data;
					default:  ;
				endcase
			end
			if (in_valid && in_ready) begin
				r = classify_and_train(mode, feature_0, feature_1, target);
				if (typed_valid)
					r = typed_res;
				pending_results.push_back(r);
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t ns: result with none expected, actual %0b%0b%0b",
						$time, prediction, updated, saturated);
					mismatch_count++;
				end else begin
					r = pending_results.pop_front();
					check_field("prediction", r.prediction, prediction);
					check_field("updated", r.updated, updated);
					check_field("saturated", r.saturated, saturated);
				end
			end
		end
	end

	// Receiver: random stall bursts, switched on and off in stretches.
	initial begin
		bit stalls_on;
		stalls_on = 1'b1;
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 63) == 0)
				stalls_on = !stalls_on;
			if (!quiet_tail && stalls_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic send_item(input stim_t s, input bit typed, input pot_pkg::res_t want);
		in_valid    <= 1'b1;
		mode        <= s.op;
		feature_0   <= s.x0;
		feature_1   <= s.x1;
		target      <= s.tgt;
		typed_valid <= typed;
		typed_res   <= want;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic maybe_pause();
		if (!quiet_tail && gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Hold input until every expected result is back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pot_pkg::CFG_IDX_W-1:0] idx,
		input logic [pot_pkg::CFG_DATA_W-1:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic script_row_t item_row(input logic [1:0] op, input int x0, input int x1,
		input logic tgt);
		script_row_t row;
		row.kind  = ROW_ITEM;
		row.s     = '{op: op, x0: pot_pkg::FEAT_W'(x0), x1: pot_pkg::FEAT_W'(x1), tgt: tgt};
		row.idx   = '0;
		row.data  = '0;
		row.typed = 1'b0;
		row.want  = '0;
		return row;
	endfunction

	function automatic script_row_t known_row(input logic [1:0] op, input int x0, input int x1,
		input logic tgt, input logic p, input logic u, input logic sat);
		script_row_t row;
		row = item_row(op, x0, x1, tgt);
		row.typed = 1'b1;
		row.want  = '{prediction: p, updated: u, saturated: sat};
		return row;
	endfunction

	function automatic script_row_t reg_row(input logic [pot_pkg::CFG_IDX_W-1:0] idx,
		input logic [pot_pkg::CFG_DATA_W-1:0] data);
		script_row_t row;
		row = item_row(pot_pkg::MODE_PREDICT, 0, 0, 1'b0);
		row.kind = ROW_WRITE;
		row.idx  = idx;
		row.data = data;
		return row;
	endfunction

	function automatic logic signed [pot_pkg::FEAT_W-1:0] pick_feature();
		case ($urandom_range(0, 9))
			7, 8: return pot_pkg::FEAT_W'($urandom_range(0, 8192)) - 16'd4096;
			9: begin
				case ($urandom_range(0, 3))
					0:       return 16'sh7FFF;
					1:       return 16'sh8000;
					2:       return '0;
					default: return '1;
				endcase
			end
			default: return pot_pkg::FEAT_W'($urandom);
		endcase
	endfunction

	function automatic logic [pot_pkg::CFG_DATA_W-1:0] pick_init();
		case ($urandom_range(0, 7))
			0:       return Q_MAX;
			1:       return Q_MIN;
			2:       return Q_MAX - $urandom_range(0, 65535);
			3:       return Q_MIN + $urandom_range(0, 65535);
			4, 5:    return $urandom;
			default: return $urandom_range(0, 2097152) - 32'd1048576;
		endcase
	endfunction

	// rate sits in the low half; the upper half is noise the unit must ignore
	function automatic logic [pot_pkg::CFG_DATA_W-1:0] pick_rate();
		logic [pot_pkg::RATE_W-1:0] r;
		case ($urandom_range(0, 5))
			0:       r = '0;
			1:       r = '1;
			2:       r = 16'd1;
			default: r = pot_pkg::RATE_W'($urandom);
		endcase
		return {16'($urandom), r};
	endfunction

	initial begin
		script_row_t script[$];
		stim_t s;
		int la;
		int lb;
		int lc;
		int pick;

		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		mode        <= pot_pkg::MODE_PREDICT;
		feature_0   <= '0;
		feature_1   <= '0;
		target      <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		typed_valid <= 1'b0;
		typed_res   <= '0;
		quiet_tail  <= 1'b0;
		gaps_on     = 1'b1;

		// zero weights after reset: net input is zero, so class 1
		script.push_back(known_row(pot_pkg::MODE_PREDICT, 0, 0, 1'b0, 1, 0, 0));
		script.push_back(known_row(pot_pkg::MODE_PREDICT, 32767, -32768, 1'b1, 1, 0, 0));
		script.push_back(known_row(MODE_SPARE, -32768, -32768, 1'b1, 1, 0, 0));
		script.push_back(known_row(pot_pkg::MODE_TRAIN, 12345, -2222, 1'b1, 1, 0, 0));
		script.push_back(known_row(pot_pkg::MODE_TRAIN, 32767, -32768, 1'b0, 1, 1, 0));
		script.push_back(item_row(pot_pkg::MODE_PREDICT, 32767, -32768, 1'b0));
		script.push_back(item_row(pot_pkg::MODE_TRAIN, -32768, 32767, 1'b1));
		script.push_back(item_row(pot_pkg::MODE_LOAD, -7, 9000, 1'b1));
		script.push_back(known_row(pot_pkg::MODE_PREDICT, 100, 100, 1'b0, 1, 0, 0));
		// zero rate: the error still flags an update
		script.push_back(reg_row(pot_pkg::REG_RATE, 32'd0));
		script.push_back(known_row(pot_pkg::MODE_TRAIN, 4096, 4096, 1'b0, 1, 1, 0));
		script.push_back(known_row(pot_pkg::MODE_PREDICT, 4096, 4096, 1'b0, 1, 0, 0));
		// rate of one: exact half-step ties round away from zero
		script.push_back(reg_row(pot_pkg::REG_RATE, 32'd1));
		script.push_back(known_row(pot_pkg::MODE_TRAIN, 2048, -2048, 1'b0, 1, 1, 0));
		script.push_back(item_row(pot_pkg::MODE_PREDICT, 2048, -2048, 1'b1));
		script.push_back(item_row(pot_pkg::MODE_TRAIN, 2047, 6144, 1'b1));
		// full rate, weights loaded at the limits
		script.push_back(reg_row(pot_pkg::REG_RATE, 32'hFFFF_FFFF));
		script.push_back(reg_row(pot_pkg::REG_IW0, Q_MAX));
		script.push_back(reg_row(pot_pkg::REG_IW1, Q_MIN));
		script.push_back(reg_row(pot_pkg::REG_BIAS, Q_MAX));
		script.push_back(reg_row(REG_UNUSED_TOP, 32'h1234_5678));
		script.push_back(reg_row(REG_UNUSED_LOW, 32'hFFFF_FFFF));
		script.push_back(item_row(pot_pkg::MODE_LOAD, 0, 0, 1'b0));
		// strongly negative net input, bias pushed past the top
		script.push_back(known_row(pot_pkg::MODE_TRAIN, -32768, 32767, 1'b1, 0, 1, 1));
		script.push_back(reg_row(pot_pkg::REG_IW0, Q_MIN));
		script.push_back(reg_row(pot_pkg::REG_IW1, Q_MAX));
		script.push_back(item_row(pot_pkg::MODE_LOAD, 1, 1, 1'b1));
		// weight zero driven below the bottom
		script.push_back(known_row(pot_pkg::MODE_TRAIN, 1, 0, 1'b0, 1, 1, 1));
		script.push_back(item_row(pot_pkg::MODE_PREDICT, -1, -1, 1'b0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[k]) begin
			if (script[k].kind == ROW_WRITE) begin
				write_reg(script[k].idx, script[k].data);
			end else begin
				send_item(script[k].s, script[k].typed, script[k].want);
				maybe_pause();
			end
		end

		// Each phase: fresh registers, a load, then mostly labeled training.
		for (int ph = 0; ph < PHASES; ph++) begin
			write_reg(pot_pkg::REG_RATE, pick_rate());
			write_reg(pot_pkg::REG_IW0, pick_init());
			write_reg(pot_pkg::REG_IW1, pick_init());
			write_reg(pot_pkg::REG_BIAS, pick_init());
			if ($urandom_range(0, 2) == 0)
				write_reg(pot_pkg::CFG_IDX_W'($urandom_range(REG_UNUSED_LOW, REG_UNUSED_TOP)),
					$urandom);
			quiet_tail <= (ph == PHASES - 1);
			// hidden separating line the perceptron is meant to learn
			la = int'($urandom_range(0, 16)) - 8;
			lb = int'($urandom_range(0, 16)) - 8;
			lc = int'($urandom_range(0, 16)) - 8;
			s = '{op: pot_pkg::MODE_LOAD, x0: pick_feature(), x1: pick_feature(),
				tgt: 1'($urandom)};
			send_item(s, 1'b0, '0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 50 == 0)
					gaps_on = ($urandom_range(0, 2) != 0);
				pick = $urandom_range(0, 99);
				if (pick < 65)
					s.op = pot_pkg::MODE_TRAIN;
				else if (pick < 82)
					s.op = pot_pkg::MODE_PREDICT;
				else if (pick < 88)
					s.op = MODE_SPARE;
				else
					s.op = pot_pkg::MODE_LOAD;
				s.x0 = pick_feature();
				s.x1 = pick_feature();
				if ($urandom_range(0, 9) < 7)
					s.tgt = (la * int'($signed(s.x0)) + lb * int'($signed(s.x1))
						+ lc * 4096 >= 0);
				else
					s.tgt = 1'($urandom);
				send_item(s, 1'b0, '0);
				maybe_pause();
			end
		end

		drain();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
